>>> hw/rtl/poly1305_mac_block_top_defines.svh
// Assertion macros for the block's checked top module
`ifndef POLY1305_MAC_BLOCK_TOP_DEFINES_SVH
`define POLY1305_MAC_BLOCK_TOP_DEFINES_SVH

// Overlapping implication, sampled on the rising clock edge
`define PMB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Non-overlapping implication, consequent checked in the next cycle
`define PMB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/pmb_pkg.sv
// Shared types and constants for the Poly1305 MAC block
package pmb_pkg;

   localparam int LimbW   = 26;
   localparam int HLimbW  = 27;
   localparam int RLimbW  = 29;
   localparam int ProdW   = HLimbW + RLimbW;
   localparam int WideW   = 164;
   localparam int AccW    = 130;

   localparam logic [127:0] RClamp = 128'h0ffffffc0ffffffc0ffffffc0fffffff;
   localparam logic [130:0] PrimeP = 131'h3fffffffffffffffffffffffffffffffb;

   localparam logic [1:0] CsrRKeyLow  = 2'd0;
   localparam logic [1:0] CsrRKeyHigh = 2'd1;
   localparam logic [1:0] CsrSKeyLow  = 2'd2;
   localparam logic [1:0] CsrSKeyHigh = 2'd3;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ADD   = 8'b0000_0010,
      ST_MUL   = 8'b0000_0100,
      ST_DRAIN = 8'b0000_1000,
      ST_RED1  = 8'b0001_0000,
      ST_RED2  = 8'b0010_0000,
      ST_RED3  = 8'b0100_0000,
      ST_TAG   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [HLimbW-1:0] a;
      logic [RLimbW-1:0] b;
      logic [2:0]        pos;
   } mul_req_type;

   typedef struct packed {
      logic             valid;
      logic [ProdW-1:0] prod;
      logic [2:0]       pos;
   } mul_rsp_type;

endpackage

>>> hw/rtl/poly1305_mac_block_top.sv
// Poly1305 MAC block: sequencer, accumulator and wide reduction around one multiplier
// Sequence: a block with bytes keeps the input stalled after its transfer through its steps
// (add, 25 limb products, drain, 3 reduce); a last block then shows its tag from ST_TAG.
// An empty block skips the arithmetic; when it is last it goes straight to ST_TAG.
// One block is in work at a time; every limb product goes through the single 27x29 multiplier.
// Reset (synchronous): keys and accumulator cleared, sequencer idle, no result valid.
`include "poly1305_mac_block_top_defines.svh"
module poly1305_mac_block_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_low,
   input  logic [63:0] req_block_high,
   input  logic [4:0]  req_byte_count,
   input  logic        req_last_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_tag_low,
   output logic [63:0] rsp_tag_high
);
   import pmb_pkg::*;

   state_type state_ff, state_in;
   logic [127:0] r_key_ff, r_key_in, s_key_ff, s_key_in;
   logic [AccW-1:0] acc_ff, acc_in;
   logic [130:0] sum_ff, sum_in;
   logic [WideW-1:0] wacc_ff, wacc_in;
   logic [2:0] hi_idx_ff, hi_idx_in, r_idx_ff, r_idx_in;
   logic [127:0] blk_ff, blk_in;
   logic [4:0] cnt_ff, cnt_in;
   logic last_ff, last_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [127:0] tag_ff, tag_in;

   logic req_xfer, tag_go;
   logic [127:0] rc;
   logic [4:0] cnt16;
   logic [127:0] mbytes;
   logic [128:0] mblk;
   logic [HLimbW-1:0] h_limb;
   logic [25:0] r_limb;
   logic [RLimbW-1:0] r_x5;
   logic [3:0] k_sum;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   logic [WideW-1:0] prod_sh;
   logic [36:0] fold5;
   logic [130:0] fold_sum;

   pmb_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign tag_go    = (state_ff == ST_TAG) && (!rsp_valid_ff || !rsp_stall);
   assign rc        = r_key_ff & RClamp;

   // pad the block and set the marker bit just above the last byte
   always_comb begin
      cnt16 = (cnt_ff > 5'd16) ? 5'd16 : cnt_ff;
      for (int b = 0; b < 16; b++) begin
         mbytes[8*b +: 8] = (5'(b) < cnt16) ? blk_ff[8*b +: 8] : 8'h00;
      end
      mblk = {1'b0, mbytes} | (129'd1 << {cnt16, 3'b000});
   end

   // operand selection for the limb product h[i] * r[j], wrapping with 5r
   always_comb begin
      case (hi_idx_ff)
         3'd0:    h_limb = {1'b0, sum_ff[25:0]};
         3'd1:    h_limb = {1'b0, sum_ff[51:26]};
         3'd2:    h_limb = {1'b0, sum_ff[77:52]};
         3'd3:    h_limb = {1'b0, sum_ff[103:78]};
         default: h_limb = sum_ff[130:104];
      endcase
      case (r_idx_ff)
         3'd0:    r_limb = rc[25:0];
         3'd1:    r_limb = rc[51:26];
         3'd2:    r_limb = rc[77:52];
         3'd3:    r_limb = rc[103:78];
         default: r_limb = {2'b00, rc[127:104]};
      endcase
      r_x5  = {1'b0, r_limb, 2'b00} + {3'b000, r_limb};
      k_sum = {1'b0, hi_idx_ff} + {1'b0, r_idx_ff};
      mul_req.valid = (state_ff == ST_MUL);
      mul_req.a     = h_limb;
      if (k_sum >= 4'd5) begin
         mul_req.b   = r_x5;
         mul_req.pos = 3'(k_sum - 4'd5);
      end else begin
         mul_req.b   = {3'b000, r_limb};
         mul_req.pos = k_sum[2:0];
      end
   end

   always_comb begin
      case (mul_rsp.pos)
         3'd0:    prod_sh = {{(WideW-ProdW){1'b0}}, mul_rsp.prod};
         3'd1:    prod_sh = {{(WideW-ProdW){1'b0}}, mul_rsp.prod} << 26;
         3'd2:    prod_sh = {{(WideW-ProdW){1'b0}}, mul_rsp.prod} << 52;
         3'd3:    prod_sh = {{(WideW-ProdW){1'b0}}, mul_rsp.prod} << 78;
         default: prod_sh = {{(WideW-ProdW){1'b0}}, mul_rsp.prod} << 104;
      endcase
      // bits at 2^130 and above come back in times five
      fold5    = {1'b0, wacc_ff[163:130], 2'b00} + {3'b000, wacc_ff[163:130]};
      fold_sum = {1'b0, wacc_ff[129:0]} + {94'd0, fold5};
   end

   always_comb begin
      state_in     = state_ff;
      r_key_in     = r_key_ff;
      s_key_in     = s_key_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      wacc_in      = wacc_ff;
      hi_idx_in    = hi_idx_ff;
      r_idx_in     = r_idx_ff;
      blk_in       = blk_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      tag_in       = tag_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CsrRKeyLow:  r_key_in[63:0]   = csr_write_data;
            CsrRKeyHigh: r_key_in[127:64] = csr_write_data;
            CsrSKeyLow:  s_key_in[63:0]   = csr_write_data;
            CsrSKeyHigh: s_key_in[127:64] = csr_write_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (mul_rsp.valid) begin
         wacc_in = wacc_ff + prod_sh;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               blk_in  = {req_block_high, req_block_low};
               cnt_in  = req_byte_count;
               last_in = req_last_block;
               if (req_byte_count != 5'd0) begin
                  state_in = ST_ADD;
               end else if (req_last_block) begin
                  state_in = ST_TAG;
               end
            end
         end
         ST_ADD: begin
            sum_in    = {1'b0, acc_ff} + {2'b00, mblk};
            wacc_in   = '0;
            hi_idx_in = 3'd0;
            r_idx_in  = 3'd0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (r_idx_ff == 3'd4) begin
               r_idx_in = 3'd0;
               if (hi_idx_ff == 3'd4) begin
                  state_in = ST_DRAIN;
               end else begin
                  hi_idx_in = hi_idx_ff + 3'd1;
               end
            end else begin
               r_idx_in = r_idx_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RED1;
         end
         ST_RED1: begin
            wacc_in  = {33'd0, fold_sum};
            state_in = ST_RED2;
         end
         ST_RED2: begin
            wacc_in  = {33'd0, fold_sum};
            state_in = ST_RED3;
         end
         ST_RED3: begin
            if (wacc_ff[130:0] >= PrimeP) begin
               acc_in = AccW'(wacc_ff[130:0] - PrimeP);
            end else begin
               acc_in = wacc_ff[129:0];
            end
            state_in = last_ff ? ST_TAG : ST_IDLE;
         end
         ST_TAG: begin
            if (tag_go) begin
               tag_in       = acc_ff[127:0] + s_key_ff;
               rsp_valid_in = 1'b1;
               acc_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         r_key_ff     <= '0;
         s_key_ff     <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hi_idx_ff    <= 3'd0;
         r_idx_ff     <= 3'd0;
      end else begin
         state_ff     <= state_in;
         r_key_ff     <= r_key_in;
         s_key_ff     <= s_key_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         hi_idx_ff    <= hi_idx_in;
         r_idx_ff     <= r_idx_in;
      end
      sum_ff  <= sum_in;
      wacc_ff <= wacc_in;
      blk_ff  <= blk_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
      tag_ff  <= tag_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tag_low  = tag_ff[63:0];
   assign rsp_tag_high = tag_ff[127:64];

   `PMB_ASSERT_NEXT(a_acc_reduced, clock, reset, (state_ff == ST_RED3),
      ({1'b0, acc_ff} < PrimeP), "accumulator not reduced below p")
   `PMB_ASSERT_NEXT(a_tag_clears, clock, reset, tag_go,
      (rsp_valid_ff && (acc_ff == '0)), "tag transfer did not clear accumulator")
   `PMB_ASSERT_NOW(a_mul_in_seq, clock, reset, mul_rsp.valid,
      ((state_ff == ST_MUL) || (state_ff == ST_DRAIN)), "product outside multiply phase")

endmodule

>>> hw/rtl/pmb_mul.sv
// Shared limb multiplier with registered product
module pmb_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  pmb_pkg::mul_req_type mul_req,
   output pmb_pkg::mul_rsp_type mul_rsp
);
   import pmb_pkg::*;

   logic             valid_ff, valid_in;
   logic [ProdW-1:0] prod_ff, prod_in;
   logic [2:0]       pos_ff, pos_in;

   always_comb begin
      valid_in = mul_req.valid;
      prod_in  = {{RLimbW{1'b0}}, mul_req.a} * {{HLimbW{1'b0}}, mul_req.b};
      pos_in   = mul_req.pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prod_ff <= prod_in;
      pos_ff  <= pos_in;
   end

   assign mul_rsp = '{valid: valid_ff, prod: prod_ff, pos: pos_ff};

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the Poly1305 MAC block: directed table, then random messages
module tb_top;
   import pmb_pkg::*;

   localparam int HoldCycles  = 300;
   localparam int SettleGap   = 40;
   localparam int WatchLimit  = 5000;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_block_low;
   logic [63:0] req_block_high;
   logic [4:0]  req_byte_count;
   logic        req_last_block;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_tag_low;
   logic [63:0] rsp_tag_high;

   poly1305_mac_block_top dut (.*);

   // predictor state
   logic [127:0] r_key, s_key;
   logic [129:0] acc_mod_p;
   logic [127:0] tag_queue[$];

   int  mismatches = 0;
   int  tags_seen  = 0;
   int  blocks_sent = 0;
   int  idle_cycles = 0;
   bit  no_idle = 0;
   bit  hold_req = 0;

   initial clock = 0;
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h want %h", what, got, want);
      mismatches++;
   endtask

   // one block into the accumulator; returns 1 and the tag on a last block
   function automatic bit mac_step(input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [4:0] cnt, input logic last,
                                   output logic [127:0] tag);
      logic [263:0] msg, prod;
      int           nbytes;
      nbytes = (cnt > 16) ? 16 : cnt;
      tag = '0;
      if (nbytes != 0) begin
         msg  = {136'b0, hi, lo} & ((264'b1 << (8 * nbytes)) - 264'b1);
         msg  = msg | (264'b1 << (8 * nbytes));
         prod = (msg + {134'b0, acc_mod_p}) * {136'b0, r_key & RClamp};
         prod = prod % {133'b0, PrimeP};
         acc_mod_p = prod[129:0];
      end
      if (!last) return 0;
      tag = acc_mod_p[127:0] + s_key;
      acc_mod_p = '0;
      return 1;
   endfunction

   task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] cnt, input logic last,
                             input bit has_tab, input logic [127:0] tab);
      int           gap;
      logic [127:0] tag;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_block_low  <= lo;
      req_block_high <= hi;
      req_byte_count <= cnt;
      req_last_block <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      blocks_sent++;
      if (mac_step(lo, hi, cnt, last, tag))
         tag_queue.push_back(has_tab ? tab : tag);
   endtask

   task automatic drain_results;
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (tag_queue.size() != 0) @(posedge clock);
      repeat (SettleGap) @(posedge clock);
   endtask

   // block idle by now; a non-last block may still be in flight, hence the settle gap
   task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CsrRKeyLow:  r_key[63:0]   = val;
         CsrRKeyHigh: r_key[127:64] = val;
         CsrSKeyLow:  s_key[63:0]   = val;
         default:     s_key[127:64] = val;
      endcase
   endtask

   task automatic load_keys(input logic [127:0] r, input logic [127:0] s);
      write_key(CsrRKeyLow,  r[63:0]);
      write_key(CsrRKeyHigh, r[127:64]);
      write_key(CsrSKeyLow,  s[63:0]);
      write_key(CsrSKeyHigh, s[127:64]);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // random message: mostly full blocks and a ragged tail, some noise counts
   task automatic send_message(input int nblocks);
      logic [4:0] cnt;
      for (int b = 0; b < nblocks; b++) begin
         if (b == nblocks - 1 || $urandom_range(0, 9) == 0)
            cnt = 5'($urandom_range(0, 31));
         else
            cnt = 5'd16;
         send_block(rand64(), rand64(), cnt, b == nblocks - 1, 0, '0);
      end
   endtask

   typedef struct {
      logic [63:0]  lo, hi;
      logic [4:0]   cnt;
      logic         last;
      bit           has_tab;
      logic [127:0] tab;
   } stim_row_type;

   stim_row_type dir_rows[$];

   // result side: random stall per transfer, and the occasional long hold
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            hold_req = 0;
         end
         n = no_idle ? 0 : $urandom_range(0, 6);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tags_seen++;
         if (tag_queue.size() == 0) begin
            report_mismatch("unexpected tag_low", rsp_tag_low, '0);
         end else begin
            if (rsp_tag_low !== tag_queue[0][63:0])
               report_mismatch("tag_low", rsp_tag_low, tag_queue[0][63:0]);
            if (rsp_tag_high !== tag_queue[0][127:64])
               report_mismatch("tag_high", rsp_tag_high, tag_queue[0][127:64]);
            void'(tag_queue.pop_front());
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= WatchLimit) begin
         $display("Timeout: no transfer for %0d cycles", WatchLimit);
         $display("Mismatches found");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      logic [127:0] ones;
      ones = '1;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CsrRKeyLow;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_block_low = '0;
      req_block_high = '0;
      req_byte_count = '0;
      req_last_block = 1'b0;
      r_key = '0;
      s_key = '0;
      acc_mod_p = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // keys zero after reset: empty message gives zero
      send_block('0, '0, 5'd0, 1'b1, 1, '0);
      // r zero: any message gives s
      send_block(rand64(), rand64(), 5'd16, 1'b1, 1, '0);
      load_keys(ones, ones);
      send_block('0, '0, 5'd0, 1'b1, 1, ones);

      dir_rows = '{
         '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b0, 0, '0},
         '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd0,  1'b0, 0, '0},
         '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd1,  1'b0, 0, '0},
         '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd7,  1'b0, 0, '0},
         '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd8,  1'b0, 0, '0},
         '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd15, 1'b0, 0, '0},
         '{64'h0000000000000000, 64'h0000000000000000, 5'd16, 1'b0, 0, '0},
         '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd31, 1'b0, 0, '0},
         '{64'hdeadbeefcafef00d, 64'h0badc0de12345678, 5'd17, 1'b1, 0, '0},
         '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b1, 0, '0},
         '{64'h8000000000000001, 64'h8000000000000001, 5'd3,  1'b1, 0, '0},
         '{64'h00000000000000ff, 64'h0,                5'd1,  1'b0, 0, '0},
         '{64'h0,                64'h0,                5'd0,  1'b1, 0, '0}
      };
      foreach (dir_rows[i])
         send_block(dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].cnt, dir_rows[i].last,
                    dir_rows[i].has_tab, dir_rows[i].tab);

      // key change between blocks of one message
      send_block(rand64(), rand64(), 5'd16, 1'b0, 0, '0);
      write_key(CsrRKeyLow, 64'h0123456789abcdef);
      send_block(rand64(), rand64(), 5'd9, 1'b1, 0, '0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: load_keys({rand64(), rand64()}, {rand64(), rand64()});
            1: load_keys(ones, '0);
            2: load_keys({rand64(), rand64()}, ones);
            default: load_keys({rand64(), rand64()}, {rand64(), rand64()});
         endcase
         no_idle = (phase == 1);
         if (phase == 2) begin
            // fill the block while results are held off
            hold_req = 1;
            for (int k = 0; k < 8; k++)
               send_block(rand64(), rand64(), 5'($urandom_range(0, 16)), 1'b1, 0, '0);
         end
         if (phase == 3) begin
            // sender waits for every tag before carrying on
            send_message(3);
            drain_results();
         end
         for (int k = 0; k < 220; ) begin
            int nb;
            nb = $urandom_range(1, 6);
            send_message(nb);
            k += nb;
         end
      end

      no_idle = 0;
      drain_results();
      $display("Covered %0d blocks and %0d tags over several key settings,", blocks_sent,
               tags_seen);
      $display("including clamp extremes, odd byte counts and a long result hold-off.");
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
